### src/sorted_merge_dedup_or_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted merge block
// Immediate-consequence and next-cycle implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef SORTED_MERGE_DEDUP_OR_MACROS_SVH
`define SORTED_MERGE_DEDUP_OR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SMDO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SMDO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/smdo_pkg.sv
// ----------------------------------------------------------------------------
// smdo_pkg
// Shared types and constants for the two-way sorted merge with duplicate union.
// ----------------------------------------------------------------------------
package smdo_pkg;

  // Width of each key and colour field on the stream ports
  localparam int FIELD_W     = 64;
  localparam int KEY_W_DEF   = 64;
  localparam int COLOR_W_DEF = 64;
  localparam int SHIFT_W     = 6;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 6'd2;

  typedef enum logic [1:0] {
    REQ_REC_A = 2'd0,
    REQ_REC_B = 2'd1,
    REQ_END_A = 2'd2,
    REQ_END_B = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    NEED_A    = 2'd0,
    NEED_B    = 2'd1,
    NEED_DONE = 2'd2
  } need_t;

endpackage

### src/sorted_merge_dedup_or.sv
// Latency: a result item is presented in the cycle after its input item is accepted.
// Throughput: one item per cycle unless the output stalls; one key compare, one B
//   colour shift and one OR/equality fold sit between the state and output registers.
// The output register accepts a new item whenever it is empty or being drained.
// Reset (synchronous, rst_n low) empties both head slots and the pending record,
//   clears both end flags and the output valid flag, and sets color_shift to 2.
// ----------------------------------------------------------------------------
// sorted_merge_dedup_or
// Merges two ascending (key, colour) streams into one, OR-ing colours of equal
// keys, with stream B colours shifted left by a configurable amount.
// ----------------------------------------------------------------------------
`include "sorted_merge_dedup_or_macros.svh"

module sorted_merge_dedup_or #(
  parameter int KEY_WIDTH   = smdo_pkg::KEY_W_DEF,
  parameter int COLOR_WIDTH = smdo_pkg::COLOR_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: color_shift
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smdo_pkg::SHIFT_W-1:0]     cfg_data,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [2*smdo_pkg::FIELD_W-1:0]   in_tdata,   // rec_key [63:0], rec_color [127:64]
  input  logic [1:0]                       in_tuser,   // req_type [1:0]
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [2*smdo_pkg::FIELD_W-1:0]   out_tdata,  // out_key [63:0], out_color [127:64]
  output logic                             out_tlast,  // out_last
  output logic [2:0]                       out_tuser   // out_valid [0], need_source [2:1]
);
  import smdo_pkg::*;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [SHIFT_W-1:0]     shift_r;

  logic [KEY_WIDTH-1:0]   ha_key_r,   ha_key_nxt;
  logic [COLOR_WIDTH-1:0] ha_col_r,   ha_col_nxt;
  logic                   ha_full_r,  ha_full_nxt;
  logic [KEY_WIDTH-1:0]   hb_key_r,   hb_key_nxt;
  logic [COLOR_WIDTH-1:0] hb_col_r,   hb_col_nxt;
  logic                   hb_full_r,  hb_full_nxt;
  logic                   a_end_r,    a_end_nxt;
  logic                   b_end_r,    b_end_nxt;
  logic [KEY_WIDTH-1:0]   pend_key_r, pend_key_nxt;
  logic [COLOR_WIDTH-1:0] pend_col_r, pend_col_nxt;
  logic                   pend_full_r, pend_full_nxt;

  // Output register
  logic                   out_vld_r;
  logic                   out_rec_r,  out_rec_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [KEY_WIDTH-1:0]   out_key_r,  out_key_nxt;
  logic [COLOR_WIDTH-1:0] out_col_r,  out_col_nxt;
  need_t                  need_r,     need_nxt;

  // Step working signals
  logic                   in_acc;
  req_type_t              req;
  logic [KEY_WIDTH-1:0]   in_key;
  logic [COLOR_WIDTH-1:0] in_col;
  logic                   pop_a, pop_b;
  logic                   eq_a, eq_b, pop_eq;
  logic [KEY_WIDTH-1:0]   pop_key;
  logic [COLOR_WIDTH-1:0] pop_col;
  logic                   emit_rec, emit_last, done;
  logic [KEY_WIDTH-1:0]   emit_key;
  logic [COLOR_WIDTH-1:0] emit_col;

  // --------------------------------------------------------------------------
  // Handshakes: the output register parts the two sides, so take a new item
  // whenever the register is empty or its item leaves this cycle.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign req    = req_type_t'(in_tuser);
  assign in_key = in_tdata[KEY_WIDTH-1:0];
  assign in_col = in_tdata[FIELD_W +: COLOR_WIDTH];

  // --------------------------------------------------------------------------
  // One merge step
  // --------------------------------------------------------------------------
  always_comb begin
    ha_key_nxt    = ha_key_r;
    ha_col_nxt    = ha_col_r;
    ha_full_nxt   = ha_full_r;
    hb_key_nxt    = hb_key_r;
    hb_col_nxt    = hb_col_r;
    hb_full_nxt   = hb_full_r;
    a_end_nxt     = a_end_r;
    b_end_nxt     = b_end_r;
    pend_key_nxt  = pend_key_r;
    pend_col_nxt  = pend_col_r;
    pend_full_nxt = pend_full_r;
    pop_a         = 1'b0;
    pop_b         = 1'b0;
    eq_a          = 1'b0;
    eq_b          = 1'b0;
    pop_eq        = 1'b0;
    pop_key       = ha_key_r;
    pop_col       = ha_col_r;
    emit_rec      = 1'b0;
    emit_last     = 1'b0;
    emit_key      = pend_key_r;
    emit_col      = pend_col_r;
    done          = 1'b0;
    need_nxt      = NEED_DONE;

    if (in_acc) begin
      // Load a head slot or mark a stream ended; records into a full head
      // or after their end marker are dropped.
      case (req)
        REQ_REC_A: begin
          if (!ha_full_r && !a_end_r) begin
            ha_key_nxt  = in_key;
            ha_col_nxt  = in_col;
            ha_full_nxt = 1'b1;
          end
        end
        REQ_REC_B: begin
          if (!hb_full_r && !b_end_r) begin
            hb_key_nxt  = in_key;
            hb_col_nxt  = in_col << shift_r;
            hb_full_nxt = 1'b1;
          end
        end
        REQ_END_A: a_end_nxt = 1'b1;
        default:   b_end_nxt = 1'b1;
      endcase

      // Pick the head to pop: smaller key, B on a tie; pass through once the
      // other stream has ended empty.
      if (ha_full_nxt && hb_full_nxt) begin
        if (ha_key_nxt < hb_key_nxt) pop_a = 1'b1;
        else                         pop_b = 1'b1;
      end else if (ha_full_nxt && b_end_nxt) begin
        pop_a = 1'b1;
      end else if (hb_full_nxt && a_end_nxt) begin
        pop_b = 1'b1;
      end

      // Compare both heads against pending in parallel with the pop choice
      eq_a    = (pend_key_r == ha_key_nxt);
      eq_b    = (pend_key_r == hb_key_nxt);
      pop_eq  = pop_a ? eq_a : eq_b;
      pop_key = pop_a ? ha_key_nxt : hb_key_nxt;
      pop_col = pop_a ? ha_col_nxt : hb_col_nxt;

      if (pop_a) ha_full_nxt = 1'b0;
      if (pop_b) hb_full_nxt = 1'b0;

      // Fold the popped record: merge colours on a repeated key, else emit
      // the pending record and hold the popped one instead.
      if (pop_a || pop_b) begin
        if (pend_full_r && pop_eq) begin
          pend_col_nxt = pend_col_r | pop_col;
        end else begin
          emit_rec      = pend_full_r;
          pend_key_nxt  = pop_key;
          pend_col_nxt  = pop_col;
          pend_full_nxt = 1'b1;
        end
      end

      // Flush the final record once both streams are drained; if this step
      // already emitted, the flush waits for the next step.
      done = a_end_nxt && b_end_nxt && !ha_full_nxt && !hb_full_nxt;
      if (done && !emit_rec && pend_full_nxt) begin
        emit_key      = pend_key_nxt;
        emit_col      = pend_col_nxt;
        emit_rec      = 1'b1;
        emit_last     = 1'b1;
        pend_full_nxt = 1'b0;
      end

      if (!done) begin
        if (!ha_full_nxt && !a_end_nxt)      need_nxt = NEED_A;
        else if (!hb_full_nxt && !b_end_nxt) need_nxt = NEED_B;
      end
    end

    out_rec_nxt  = emit_rec;
    out_last_nxt = emit_last;
    out_key_nxt  = emit_rec ? emit_key : '0;
    out_col_nxt  = emit_rec ? emit_col : '0;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= SHIFT_RST;
      ha_full_r   <= 1'b0;
      hb_full_r   <= 1'b0;
      a_end_r     <= 1'b0;
      b_end_r     <= 1'b0;
      pend_full_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) shift_r <= cfg_data;
      ha_full_r   <= ha_full_nxt;
      hb_full_r   <= hb_full_nxt;
      a_end_r     <= a_end_nxt;
      b_end_r     <= b_end_nxt;
      pend_full_r <= pend_full_nxt;
      if (in_acc)          out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // Payload: heads and pending hold whenever no item arrives
  always_ff @(posedge clk) begin
    ha_key_r   <= ha_key_nxt;
    ha_col_r   <= ha_col_nxt;
    hb_key_r   <= hb_key_nxt;
    hb_col_r   <= hb_col_nxt;
    pend_key_r <= pend_key_nxt;
    pend_col_r <= pend_col_nxt;
    if (in_acc) begin
      out_rec_r  <= out_rec_nxt;
      out_last_r <= out_last_nxt;
      out_key_r  <= out_key_nxt;
      out_col_r  <= out_col_nxt;
      need_r     <= need_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result port
  // --------------------------------------------------------------------------
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {FIELD_W'(out_col_r), FIELD_W'(out_key_r)};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {need_r, out_rec_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SMDO_ASSERT_IMP(a_heads_never_both_full, 1'b1, !(ha_full_r && hb_full_r), "both heads held full")
  `SMDO_ASSERT_NXT(a_result_held, out_vld_r && !out_tready, out_vld_r && $stable(out_tdata), "result item changed while stalled")
  `SMDO_ASSERT_IMP(a_last_is_record, out_vld_r && out_last_r, out_rec_r, "last flag without record")
  `SMDO_ASSERT_NXT(a_final_clears_pending, in_acc && emit_last, !pend_full_r, "pending kept after final")

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-way sorted merge with duplicate union. One
// long merge is driven through the stream ports with bursty input pacing and a
// patterned output stall. A behavioural merge model predicts every result item,
// and each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import smdo_pkg::*;

  localparam logic [63:0] KEY_MAX = '1;
  localparam logic [63:0] END_KEY_BASE = 64'hFFFF_FFFF_FFFF_FF00;

  // receiver stall patterns
  localparam int RX_OPEN     = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SHIFT_W-1:0]     cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [2*FIELD_W-1:0]   in_tdata;   // rec_key [63:0], rec_color [127:64]
  logic [1:0]             in_tuser;   // req_type [1:0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [2*FIELD_W-1:0]   out_tdata;  // out_key [63:0], out_color [127:64]
  logic                   out_tlast;  // out_last
  logic [2:0]             out_tuser;  // out_valid [0], need_source [2:1]

  sorted_merge_dedup_or u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // One predicted result item: one per accepted input item
  typedef struct {
    logic        valid;
    logic [63:0] key;
    logic [63:0] color;
    logic        last;
    need_t       need;
  } merged_item_t;

  merged_item_t merged_q[$];

  // Predictor state: one head slot per stream, the end flags and the record
  // still being folded. It mirrors the block from reset onwards.
  logic [SHIFT_W-1:0] shift_b = SHIFT_RST;
  logic [63:0] slot_a_key = '0, slot_a_color = '0;
  logic [63:0] slot_b_key = '0, slot_b_color = '0;
  logic        slot_a_full = 1'b0, slot_b_full = 1'b0;
  logic        a_closed = 1'b0, b_closed = 1'b0;
  logic [63:0] fold_key = '0, fold_color = '0;
  logic        fold_full = 1'b0;
  need_t       want_src = NEED_A;

  bit          item_taken;      // last accepted item changed the merge state
  bit          gaps_on = 1'b1;  // sender inserts gaps between bursts
  int          burst_left = 0;
  int          hold_request = 0;
  int          mismatches = 0;
  logic [63:0] key_cursor = '0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Merge predictor
  // --------------------------------------------------------------------------

  // Fold a popped record into the open record; true when the open one leaves.
  function automatic bit fold_popped(input logic [63:0] k, input logic [63:0] c,
                                     output logic [63:0] ek, output logic [63:0] ec);
    bit emitted;
    emitted = 1'b0;
    if (fold_full && fold_key == k) begin
      fold_color |= c;
      return 1'b0;
    end
    if (fold_full) begin
      ek = fold_key;
      ec = fold_color;
      emitted = 1'b1;
    end
    fold_key   = k;
    fold_color = c;
    fold_full  = 1'b1;
    return emitted;
  endfunction

  function automatic merged_item_t merge_step(input req_type_t req,
                                              input logic [63:0] k,
                                              input logic [63:0] c);
    merged_item_t r;
    logic [63:0]  ek, ec;
    bit           pop_a, pop_b, finished;
    ek = '0;
    ec = '0;
    pop_a = 1'b0;
    pop_b = 1'b0;
    r.valid = 1'b0;
    r.last  = 1'b0;
    item_taken = 1'b0;
    case (req)
      REQ_REC_A: begin
        if (!slot_a_full && !a_closed) begin
          slot_a_key = k;
          slot_a_color = c;
          slot_a_full = 1'b1;
          item_taken = 1'b1;
        end
      end
      REQ_REC_B: begin
        if (!slot_b_full && !b_closed) begin
          slot_b_key = k;
          slot_b_color = c << shift_b;
          slot_b_full = 1'b1;
          item_taken = 1'b1;
        end
      end
      REQ_END_A: begin
        item_taken = !a_closed;
        a_closed = 1'b1;
      end
      default: begin
        item_taken = !b_closed;
        b_closed = 1'b1;
      end
    endcase

    // Pop the smaller head, B on a tie; pass a head through once the other
    // stream has closed with its slot empty.
    if (slot_a_full && slot_b_full) begin
      if (slot_a_key < slot_b_key) pop_a = 1'b1;
      else pop_b = 1'b1;
    end else if (slot_a_full && b_closed) begin
      pop_a = 1'b1;
    end else if (slot_b_full && a_closed) begin
      pop_b = 1'b1;
    end

    if (pop_a) begin
      slot_a_full = 1'b0;
      r.valid = fold_popped(slot_a_key, slot_a_color, ek, ec);
    end else if (pop_b) begin
      slot_b_full = 1'b0;
      r.valid = fold_popped(slot_b_key, slot_b_color, ek, ec);
    end

    // Flush the open record when everything is in, unless this step already
    // emitted one: then it goes out on the next step.
    finished = a_closed && b_closed && !slot_a_full && !slot_b_full;
    if (finished && !r.valid && fold_full) begin
      ek = fold_key;
      ec = fold_color;
      r.valid = 1'b1;
      r.last = 1'b1;
      fold_full = 1'b0;
    end

    r.need = NEED_DONE;
    if (!finished) begin
      if (!slot_a_full && !a_closed) r.need = NEED_A;
      else if (!slot_b_full && !b_closed) r.need = NEED_B;
    end
    r.key   = r.valid ? ek : '0;
    r.color = r.valid ? ec : '0;
    want_src = r.need;
    return r;
  endfunction

  function automatic logic [63:0] random_color();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return 64'h1 << $urandom_range(0, 63);
      2: return '1;
      default: return {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one item, hold it until accepted, then predict its result item.
  task automatic send_item(input req_type_t req, input logic [63:0] k,
                           input logic [63:0] c);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {c, k};
    do @(posedge clk); while (!in_tready);
    merged_q.push_back(merge_step(req, k, c));
    // close the burst with a gap when it runs out
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 6);
        @(negedge clk) in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  // Drop valid and wait for every predicted result item to drain.
  task automatic settle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shift_b = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed records for the stream the block asks for, with keys
  // rising on a shared cursor so equal keys meet inside and across streams.
  // A few items go into an occupied slot (dropped) or arrive out of order.
  task automatic feed_merge(input int count);
    int          taken, pick;
    logic [63:0] k;
    req_type_t   rq;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8 && (slot_a_full || slot_b_full)) begin
        rq = req_type_t'(slot_a_full ? REQ_REC_A : REQ_REC_B);
        k  = {$urandom, $urandom};
      end else begin
        rq = req_type_t'((want_src == NEED_B) ? REQ_REC_B : REQ_REC_A);
        if (pick < 14 && key_cursor > 64) begin
          k = key_cursor - 64'($urandom_range(0, 40));
        end else begin
          key_cursor += 64'((pick < 16) ? $urandom_range(1, 1 << 20) : $urandom_range(0, 2));
          k = key_cursor;
        end
      end
      send_item(rq, k, random_color());
      if (item_taken) taken++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: windows of open, random or periodic stalls, plus a long
  // hold-off on request, counted here.
  // --------------------------------------------------------------------------
  initial begin : rx_pattern
    int window, mode, hold, phase;
    window = 0;
    mode = RX_OPEN;
    hold = 0;
    phase = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        if (window == 0) begin
          window = $urandom_range(16, 96);
          mode = $urandom_range(RX_OPEN, RX_PERIODIC);
        end
        window--;
        phase++;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
          default:   out_tready <= (phase % 4 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    merged_item_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (merged_q.size() == 0) begin
        report_mismatch("unexpected result item", out_tdata[63:0], '0);
      end else begin
        e = merged_q.pop_front();
        if (out_tuser[0] !== e.valid)
          report_mismatch("out_valid", 64'(out_tuser[0]), 64'(e.valid));
        if (out_tdata[63:0] !== e.key) report_mismatch("out_key", out_tdata[63:0], e.key);
        if (out_tdata[127:64] !== e.color)
          report_mismatch("out_color", out_tdata[127:64], e.color);
        if (out_tlast !== e.last) report_mismatch("out_last", 64'(out_tlast), 64'(e.last));
        if (out_tuser[2:1] !== e.need)
          report_mismatch("need_source", 64'(out_tuser[2:1]), 64'(e.need));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset shift of 2; key zero; ties popping B first; B colours losing their
  // top bits to the shift; a record into an occupied slot.
  task automatic test_directed();
    send_item(REQ_REC_A, 64'd0, '1);
    send_item(REQ_REC_A, 64'd5, 64'h1);                     // slot A occupied: drop
    send_item(REQ_REC_B, 64'd0, 64'h1);                     // tie: B first
    send_item(REQ_REC_B, 64'd0, 64'h8000_0000_0000_0001);   // top bit shifted out
    send_item(REQ_REC_B, 64'd3, 64'hF0);
    send_item(REQ_REC_A, 64'd3, 64'h0F);
    send_item(REQ_REC_B, 64'd4, 64'hC000_0000_0000_0000);
    send_item(REQ_REC_A, 64'd4, 64'h0);
    send_item(REQ_REC_A, 64'd6, 64'h5555_5555_5555_5555);
    send_item(REQ_REC_B, 64'd6, 64'hAAAA_AAAA_AAAA_AAAA);
    key_cursor = 64'd8;
  endtask

  // Run the merge at both shift extremes and one in between.
  task automatic test_shift_sweep();
    write_shift('0);
    feed_merge(80);
    write_shift('1);
    feed_merge(80);
    write_shift(6'd1);
    feed_merge(80);
  endtask

  // Hold the output for a long stretch while the sender keeps offering, so
  // the output register fills and the input stalls.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 200;
    feed_merge(40);
    gaps_on = 1'b1;
  endtask

  // Bulk random merge in phases, each with its own shift; one phase without
  // sender gaps.
  task automatic test_random_merge();
    for (int ph = 0; ph < 4; ph++) begin
      gaps_on = (ph != 1);
      write_shift($urandom_range(1, 62));
      feed_merge(215);
    end
    gaps_on = 1'b1;
  endtask

  // Close both streams: end of A while its slot is occupied, records and end
  // markers after the close, a pass-through pop, the deferred final record,
  // and steps after the final record.
  task automatic test_close();
    logic [63:0] k;
    int          guard;
    k = END_KEY_BASE;
    guard = 0;
    // advance until slot A holds a key that differs from the open record
    while (!(want_src == NEED_B && slot_a_full && fold_full && slot_a_key != fold_key)
           && guard < 40) begin
      send_item(req_type_t'((want_src == NEED_B) ? REQ_REC_B : REQ_REC_A), k,
                random_color());
      k += 64'($urandom_range(1, 3));
      guard++;
    end
    send_item(REQ_END_A, {$urandom, $urandom}, random_color());
    send_item(REQ_REC_A, k, random_color());                 // after close: drop
    send_item(REQ_END_A, '0, '0);                            // repeated close
    send_item(REQ_REC_B, KEY_MAX, '1);                       // pops held A record
    send_item(REQ_END_B, {$urandom, $urandom}, random_color()); // final deferred
    send_item(REQ_REC_B, {$urandom, $urandom}, random_color()); // final goes out
    repeat (6)
      send_item(req_type_t'($urandom_range(0, 3)), {$urandom, $urandom}, random_color());
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_REC_A;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed();
    test_shift_sweep();
    test_backpressure();
    test_random_merge();
    test_close();

    // drain, then wait for the output register to empty
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && merged_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
